// ===== hw/rtl/mcsc_pkg.sv =====
// Shared constants, codes and types of the motion classifier and step counter.
package mcsc_pkg;

	localparam int unsigned WINDOW_LEN_DEF = 16;

	localparam int unsigned FIELD_W    = 16;
	localparam int unsigned ABS_W      = FIELD_W + 1;
	localparam int unsigned PROD_W     = 2 * ABS_W;
	localparam int unsigned SQ_W       = 31;
	localparam int unsigned ACC_W      = 32;
	localparam int unsigned MAG_W      = 16;
	localparam int unsigned GRAV_W     = 12;
	localparam int unsigned LIM_W      = 14;
	localparam int unsigned LIM_SUM_W  = 15;
	localparam int unsigned STEP_W     = 24;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 14;
	localparam int unsigned NUM_AXES   = 6;
	localparam int unsigned AXIS_W     = 3;

	localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};

	localparam logic [GRAV_W-1:0] GRAV_RST        = 12'd2509;
	localparam logic [LIM_W-1:0]  STILL_ACCEL_RST = 14'd128;
	localparam logic [LIM_W-1:0]  STILL_GYRO_RST  = 14'd128;
	localparam logic [LIM_W-1:0]  WALK_RST        = 14'd512;
	localparam logic [LIM_W-1:0]  RUN_RST         = 14'd1280;
	localparam logic [LIM_W-1:0]  STEP_LIM_RST    = 14'd384;

	localparam logic [AXIS_W-1:0] AXIS_LAST       = 3'd5;
	localparam logic [AXIS_W-1:0] AXIS_FIRST_RATE = 3'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRAVITY     = 3'd0,
		REG_STILL_ACCEL = 3'd1,
		REG_STILL_GYRO  = 3'd2,
		REG_WALK        = 3'd3,
		REG_RUN         = 3'd4,
		REG_STEP        = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CLS_STAND = 2'd0,
		CLS_WALK  = 2'd1,
		CLS_RUN   = 2'd2,
		CLS_JUMP  = 2'd3
	} motion_class_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] accel_x;
		logic signed [FIELD_W-1:0] accel_y;
		logic signed [FIELD_W-1:0] accel_z;
		logic signed [FIELD_W-1:0] rate_x;
		logic signed [FIELD_W-1:0] rate_y;
		logic signed [FIELD_W-1:0] rate_z;
	} sample_t;

	// controller -> datapath
	typedef struct packed {
		logic              load;
		logic              sq_go;
		logic [AXIS_W-1:0] sq_idx;
		logic              root_start;
		logic              root_rate;
		logic              take_a;
		logic              take_r;
		logic              update;
		logic              emit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic root_done;
		logic out_free;
	} sts_t;

endpackage

// ===== hw/rtl/mcsc_if.sv =====
// Valid/ready channel interfaces: sample input, result output, register writes.
interface mcsc_sample_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [mcsc_pkg::FIELD_W-1:0]  accel_x;
	logic signed [mcsc_pkg::FIELD_W-1:0]  accel_y;
	logic signed [mcsc_pkg::FIELD_W-1:0]  accel_z;
	logic signed [mcsc_pkg::FIELD_W-1:0]  rate_x;
	logic signed [mcsc_pkg::FIELD_W-1:0]  rate_y;
	logic signed [mcsc_pkg::FIELD_W-1:0]  rate_z;

	modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
		input ready);
	modport sink (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
		output ready);
endinterface

interface mcsc_result_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    motion_class;
	logic [mcsc_pkg::STEP_W-1:0]   step_total;
	logic                          step_seen;

	modport source (output valid, motion_class, step_total, step_seen, input ready);
	modport sink (input valid, motion_class, step_total, step_seen, output ready);
endinterface

interface mcsc_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [mcsc_pkg::CFG_IDX_W-1:0]    index;
	logic [mcsc_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/mcsc_isqrt.sv =====
// Bit-serial floor square root, one root bit per cycle.
module mcsc_isqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [mcsc_pkg::ACC_W-1:0]   operand,
	output logic                         done,
	output logic [mcsc_pkg::MAG_W-1:0]   root
);

	localparam int unsigned CNT_W = $clog2(mcsc_pkg::MAG_W);
	localparam int unsigned REM_W = mcsc_pkg::MAG_W + 1;
	localparam int unsigned SH_W  = REM_W + 2;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(mcsc_pkg::MAG_W - 1);

	logic [mcsc_pkg::ACC_W-1:0] op_q;
	logic [REM_W-1:0]           rem_q;
	logic [mcsc_pkg::MAG_W-1:0] root_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;

	logic [SH_W-1:0] shifted;
	logic [SH_W-1:0] trial;
	logic [SH_W-1:0] diff;
	logic            fits;

	// next remainder with two operand bits brought down, against 4*root+1
	assign shifted = {rem_q, op_q[mcsc_pkg::ACC_W-1 -: 2]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign diff    = shifted - trial;
	assign fits    = (shifted >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q   <= operand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			op_q <= {op_q[mcsc_pkg::ACC_W-3:0], 2'b00};
			if (fits) begin
				rem_q  <= diff[REM_W-1:0];
				root_q <= {root_q[mcsc_pkg::MAG_W-2:0], 1'b1};
			end else begin
				rem_q  <= shifted[REM_W-1:0];
				root_q <= {root_q[mcsc_pkg::MAG_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== hw/rtl/mcsc_dp.sv =====
// Datapath: registers, squarer, root unit, window ring, sums, classifier, result register.
module mcsc_dp #(
	parameter int unsigned WINDOW_LEN = mcsc_pkg::WINDOW_LEN_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mcsc_pkg::cmd_t                    cmd,
	output mcsc_pkg::sts_t                    sts,
	input  mcsc_pkg::sample_t                 smp,
	input  logic                              cfg_valid,
	input  logic [mcsc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mcsc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                              cfg_ready,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        motion_class,
	output logic [mcsc_pkg::STEP_W-1:0]       step_total,
	output logic                              step_seen
);

	localparam int unsigned POS_W = $clog2(WINDOW_LEN);
	localparam int unsigned SUM_W = mcsc_pkg::MAG_W + $clog2(WINDOW_LEN);
	localparam int unsigned ENT_W = 2 * mcsc_pkg::MAG_W;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_LEN - 1);
	localparam logic [SUM_W-1:0] N_SUM    = SUM_W'(WINDOW_LEN);

	// configuration registers
	logic [mcsc_pkg::GRAV_W-1:0] grav_q;
	logic [mcsc_pkg::LIM_W-1:0]  still_a_q;
	logic [mcsc_pkg::LIM_W-1:0]  still_g_q;
	logic [mcsc_pkg::LIM_W-1:0]  walk_q;
	logic [mcsc_pkg::LIM_W-1:0]  run_q;
	logic [mcsc_pkg::LIM_W-1:0]  step_lim_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q     <= mcsc_pkg::GRAV_RST;
			still_a_q  <= mcsc_pkg::STILL_ACCEL_RST;
			still_g_q  <= mcsc_pkg::STILL_GYRO_RST;
			walk_q     <= mcsc_pkg::WALK_RST;
			run_q      <= mcsc_pkg::RUN_RST;
			step_lim_q <= mcsc_pkg::STEP_LIM_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mcsc_pkg::REG_GRAVITY:     grav_q     <= cfg_data[mcsc_pkg::GRAV_W-1:0];
				mcsc_pkg::REG_STILL_ACCEL: still_a_q  <= cfg_data;
				mcsc_pkg::REG_STILL_GYRO:  still_g_q  <= cfg_data;
				mcsc_pkg::REG_WALK:        walk_q     <= cfg_data;
				mcsc_pkg::REG_RUN:         run_q      <= cfg_data;
				mcsc_pkg::REG_STEP:        step_lim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// window thresholds N*(G+L), and N*L for the still gyro limit, refreshed every cycle from the registers
	logic [mcsc_pkg::LIM_SUM_W-1:0] gl_still;
	logic [mcsc_pkg::LIM_SUM_W-1:0] gl_walk;
	logic [mcsc_pkg::LIM_SUM_W-1:0] gl_run;
	logic [mcsc_pkg::LIM_SUM_W-1:0] step_thr;
	logic [SUM_W-1:0] thr_still_a_q;
	logic [SUM_W-1:0] thr_still_g_q;
	logic [SUM_W-1:0] thr_walk_q;
	logic [SUM_W-1:0] thr_run_q;

	assign gl_still = {3'b000, grav_q} + {1'b0, still_a_q};
	assign gl_walk  = {3'b000, grav_q} + {1'b0, walk_q};
	assign gl_run   = {3'b000, grav_q} + {1'b0, run_q};
	assign step_thr = {3'b000, grav_q} + {1'b0, step_lim_q};

	always_ff @(posedge clk) begin
		thr_still_a_q <= N_SUM * SUM_W'(gl_still);
		thr_still_g_q <= N_SUM * SUM_W'(still_g_q);
		thr_walk_q    <= N_SUM * SUM_W'(gl_walk);
		thr_run_q     <= N_SUM * SUM_W'(gl_run);
	end

	// sample capture and sum of squares, one axis per cycle
	mcsc_pkg::sample_t smp_q;
	logic [mcsc_pkg::FIELD_W-1:0] axis_v;
	logic [mcsc_pkg::ABS_W-1:0]   abs_v;
	logic [mcsc_pkg::PROD_W-1:0]  prod_full;
	logic [mcsc_pkg::SQ_W-1:0]    prod_q;
	logic                         sq_v_q;
	logic                         sq_rate_q;
	logic [mcsc_pkg::ACC_W-1:0]   acc_a_q;
	logic [mcsc_pkg::ACC_W-1:0]   acc_r_q;

	always_comb begin
		unique case (cmd.sq_idx)
			3'd0:    axis_v = smp_q.accel_x;
			3'd1:    axis_v = smp_q.accel_y;
			3'd2:    axis_v = smp_q.accel_z;
			3'd3:    axis_v = smp_q.rate_x;
			3'd4:    axis_v = smp_q.rate_y;
			3'd5:    axis_v = smp_q.rate_z;
			default: axis_v = '0;
		endcase
	end

	// |x| needs 17 bits for the most negative input
	assign abs_v = axis_v[mcsc_pkg::FIELD_W-1] ?
		(mcsc_pkg::ABS_W'(0) - {1'b1, axis_v}) : {1'b0, axis_v};
	assign prod_full = {{(mcsc_pkg::PROD_W - mcsc_pkg::ABS_W){1'b0}}, abs_v} *
		{{(mcsc_pkg::PROD_W - mcsc_pkg::ABS_W){1'b0}}, abs_v};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_q    <= 1'b0;
			sq_rate_q <= 1'b0;
		end else begin
			sq_v_q    <= cmd.sq_go;
			sq_rate_q <= (cmd.sq_idx >= mcsc_pkg::AXIS_FIRST_RATE);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			smp_q <= smp;
		end
		prod_q <= prod_full[mcsc_pkg::SQ_W-1:0];
		if (cmd.load) begin
			acc_a_q <= '0;
			acc_r_q <= '0;
		end else if (sq_v_q) begin
			if (sq_rate_q) begin
				acc_r_q <= acc_r_q + {1'b0, prod_q};
			end else begin
				acc_a_q <= acc_a_q + {1'b0, prod_q};
			end
		end
	end

	// shared root unit
	logic                       root_done;
	logic [mcsc_pkg::MAG_W-1:0] root;
	logic [mcsc_pkg::MAG_W-1:0] amag_q;
	logic [mcsc_pkg::MAG_W-1:0] rmag_q;

	mcsc_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.root_start),
		.operand (cmd.root_rate ? acc_r_q : acc_a_q),
		.done    (root_done),
		.root    (root)
	);

	always_ff @(posedge clk) begin
		if (cmd.take_a) begin
			amag_q <= root;
		end
		if (cmd.take_r) begin
			rmag_q <= root;
		end
	end

	// window ring: {accel mag, rate mag} per slot, valid bit per slot
	logic [ENT_W-1:0]       ring_mem [WINDOW_LEN];
	logic [WINDOW_LEN-1:0]  ring_vld_q;
	logic [ENT_W-1:0]       old_q;
	logic                   old_vld_q;
	logic [POS_W-1:0]       pos_q;
	logic [mcsc_pkg::MAG_W-1:0] old_a;
	logic [mcsc_pkg::MAG_W-1:0] old_r;

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			ring_mem[pos_q] <= {amag_q, rmag_q};
		end
		if (cmd.load) begin
			old_q <= ring_mem[pos_q];
		end
	end

	// a slot never written holds a zero magnitude
	assign old_a = old_vld_q ? old_q[ENT_W-1 -: mcsc_pkg::MAG_W] : '0;
	assign old_r = old_vld_q ? old_q[mcsc_pkg::MAG_W-1:0] : '0;

	// running sums, step counter
	logic [SUM_W-1:0]            asum_q;
	logic [SUM_W-1:0]            rsum_q;
	logic [mcsc_pkg::STEP_W-1:0] step_q;
	logic                        seen;

	assign seen = (amag_q > {1'b0, step_thr});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_vld_q <= '0;
			old_vld_q  <= 1'b0;
			pos_q      <= '0;
			asum_q     <= '0;
			rsum_q     <= '0;
			step_q     <= '0;
		end else begin
			if (cmd.load) begin
				old_vld_q <= ring_vld_q[pos_q];
			end
			if (cmd.update) begin
				ring_vld_q[pos_q] <= 1'b1;
				pos_q  <= (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;
				asum_q <= asum_q - SUM_W'(old_a) + SUM_W'(amag_q);
				rsum_q <= rsum_q - SUM_W'(old_r) + SUM_W'(rmag_q);
				if (seen && (step_q != mcsc_pkg::STEP_MAX)) begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	// classification on the updated window
	mcsc_pkg::motion_class_t cls;

	always_comb begin
		priority if ((asum_q < thr_still_a_q) && (rsum_q < thr_still_g_q)) begin
			cls = mcsc_pkg::CLS_STAND;
		end else if (asum_q < thr_walk_q) begin
			cls = mcsc_pkg::CLS_WALK;
		end else if (asum_q < thr_run_q) begin
			cls = mcsc_pkg::CLS_RUN;
		end else begin
			cls = mcsc_pkg::CLS_JUMP;
		end
	end

	// result register
	logic                        out_full_q;
	mcsc_pkg::motion_class_t     cls_q;
	logic [mcsc_pkg::STEP_W-1:0] total_q;
	logic                        seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (cmd.emit) begin
			out_full_q <= 1'b1;
		end else if (out_ready) begin
			out_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			cls_q   <= cls;
			total_q <= step_q;
			seen_q  <= seen;
		end
	end

	assign sts.root_done = root_done;
	assign sts.out_free  = !out_full_q || out_ready;

	assign out_valid    = out_full_q;
	assign motion_class = cls_q;
	assign step_total   = total_q;
	assign step_seen    = seen_q;

endmodule

// ===== hw/rtl/mcsc_ctrl.sv =====
// Controller: sequences one sample through squares, two roots, update and result.
module mcsc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  mcsc_pkg::sts_t sts,
	output mcsc_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SQUARE,
		S_FLUSH,
		S_ROOT_A,
		S_ROOT_R,
		S_UPDATE,
		S_EMIT
	} state_t;

	state_t                        state_q;
	logic [mcsc_pkg::AXIS_W-1:0]   axis_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SQUARE;
						axis_q  <= '0;
					end
				end
				S_SQUARE: begin
					if (axis_q == mcsc_pkg::AXIS_LAST) begin
						state_q <= S_FLUSH;
					end else begin
						axis_q <= axis_q + 1'b1;
					end
				end
				S_FLUSH: state_q <= S_ROOT_A;
				S_ROOT_A: begin
					if (sts.root_done) begin
						state_q <= S_ROOT_R;
					end
				end
				S_ROOT_R: begin
					if (sts.root_done) begin
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: state_q <= S_EMIT;
				S_EMIT: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.load       = (state_q == S_IDLE) && in_valid;
		cmd.sq_go      = (state_q == S_SQUARE);
		cmd.sq_idx     = axis_q;
		// accel root starts once its three squares are in; rate root follows it
		cmd.root_start = (state_q == S_FLUSH) || ((state_q == S_ROOT_A) && sts.root_done);
		cmd.root_rate  = (state_q == S_ROOT_A);
		cmd.take_a     = (state_q == S_ROOT_A) && sts.root_done;
		cmd.take_r     = (state_q == S_ROOT_R) && sts.root_done;
		cmd.update     = (state_q == S_UPDATE);
		cmd.emit       = (state_q == S_EMIT) && sts.out_free;
	end

endmodule

// ===== hw/rtl/motion_classifier_step_counter_core.sv =====
// Top level of the motion classifier and step counter.
//
// One 6-axis sample in, one result out. The input takes a new sample only
// once the last one has loaded its result. Each sample goes through the
// single shared squarer (one axis a cycle, then a drain step) and the single
// bit-serial root unit, which works through its 16 steps first for the
// acceleration magnitude and then for the rotation magnitude; then the window
// is updated and the result loaded. A result that still waits for its
// transfer holds the controller in its result step until the output register
// frees, and the input stays closed until then. Magnitudes are floor square
// roots of the sum of squares, in the input's 1/256 units. The last
// WINDOW_LEN magnitudes of each kind sit in a ring (a slot never written
// counts as zero, so the window starts as all zeros) with running sums;
// classification compares those sums with WINDOW_LEN*(gravity+limit), and the
// rotation sum with WINDOW_LEN*still_gyro_limit, and needs no divide. A step
// counts when this sample's acceleration magnitude is strictly above
// gravity+step_limit; the 24-bit total sticks at its maximum, while step_seen
// still reports the test. The result sits in an output register, so a new
// sample can be taken while the last result waits for its transfer. Register
// writes (index 0..5: gravity_level, still_accel_limit, still_gyro_limit,
// walk_limit, run_limit, step_limit) are always ready, keep the register's
// own width of the data, ignore indexes above 5, and must only be made while
// no sample is in flight. No clearing pass is needed after reset.
module motion_classifier_step_counter_core #(
	parameter int unsigned WINDOW_LEN = mcsc_pkg::WINDOW_LEN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	mcsc_sample_if.sink   sample,
	mcsc_result_if.source result,
	mcsc_cfg_if.sink      cfg
);

	mcsc_pkg::cmd_t    cmd;
	mcsc_pkg::sts_t    sts;
	mcsc_pkg::sample_t smp;

	assign smp.accel_x = sample.accel_x;
	assign smp.accel_y = sample.accel_y;
	assign smp.accel_z = sample.accel_z;
	assign smp.rate_x  = sample.rate_x;
	assign smp.rate_y  = sample.rate_y;
	assign smp.rate_z  = sample.rate_z;

	// sequencer: one sample at a time
	mcsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// arithmetic, window ring, config registers and result register
	mcsc_dp #(
		.WINDOW_LEN (WINDOW_LEN)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.smp          (smp),
		.cfg_valid    (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.cfg_ready    (cfg.ready),
		.out_valid    (result.valid),
		.out_ready    (result.ready),
		.motion_class (result.motion_class),
		.step_total   (result.step_total),
		.step_seen    (result.step_seen)
	);

	// a sample transfer closes the input until that sample is done
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> !sample.ready)
		else $error("input taken again while a sample is in flight");

	// the root unit only finishes while a sample is being worked on
	a_root_mid_item: assert property (@(posedge clk) disable iff (!arst_n)
		sts.root_done |-> !sample.ready)
		else $error("root unit finished while the controller is idle");

	// a counted step implies a nonzero total, saturation included
	a_step_total: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.step_seen |-> result.step_total != '0)
		else $error("step reported but total is zero");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the motion classifier and step counter core.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mcsc_pkg::*;

	// Window depth used both by the instance and by the predictor below.
	localparam int unsigned WIN = WINDOW_LEN_DEF;

	// Register indexes past the last real register; writes there must be dropped.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	// Receiver hold-off used to back the core up into its input.
	localparam int unsigned LONG_HOLD = 400;

	// Kinds of movement the random stimulus imitates; NOISE is raw full-range data.
	typedef enum int {
		GAIT_STILL,
		GAIT_WALK,
		GAIT_RUN,
		GAIT_JUMP,
		GAIT_SPIN,
		GAIT_NOISE
	} gait_t;

	// One expected result transfer.
	typedef struct packed {
		motion_class_t          cls;
		logic [STEP_W-1:0]      total;
		logic                   seen;
	} step_report_t;

	// One row of the directed part; pinned rows carry a hand-worked result.
	typedef struct packed {
		sample_t                s;
		logic                   pinned;
		step_report_t           want;
	} probe_t;

	logic clk = 1'b0;
	logic arst_n;

	mcsc_sample_if smp_bus ();
	mcsc_result_if res_bus ();
	mcsc_cfg_if    cfg_bus ();

	motion_classifier_step_counter_core #(
		.WINDOW_LEN(WIN)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.sample(smp_bus),
		.result(res_bus),
		.cfg   (cfg_bus)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Predictor: register copy plus window state
	// ---------------------------------------------------------------
	logic [GRAV_W-1:0] grav_lvl;
	logic [LIM_W-1:0]  still_acc_lim;
	logic [LIM_W-1:0]  still_rot_lim;
	logic [LIM_W-1:0]  walk_lim;
	logic [LIM_W-1:0]  run_lim;
	logic [LIM_W-1:0]  step_lim;

	logic [MAG_W-1:0]  acc_ring [WIN];
	logic [MAG_W-1:0]  rot_ring [WIN];
	int unsigned       ring_slot;
	int unsigned       acc_window_sum;
	int unsigned       rot_window_sum;
	logic [STEP_W-1:0] step_tally;

	step_report_t      expected_reports [$];

	// bookkeeping
	int unsigned faults;
	int unsigned samples_in;
	int unsigned reports_out;
	int unsigned steps_flagged;
	int unsigned settings_used;
	int unsigned class_hits [4];

	// pacing flags, written with NBAs from the stimulus thread
	logic quiet_tail;
	logic hold_go;
	logic hold_done;
	int unsigned hold_left;
	int unsigned burst_left;

	// Directed rows. Only the first two results are pinned by hand: all-zero
	// after reset stands still; an all-minimum accel vector gives a magnitude
	// of 56755, a step, and a window sum between the walk and run bounds.
	probe_t probes [15] = '{
		'{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
			1'b1, '{CLS_STAND, 24'd0, 1'b0}},
		'{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sd0, 16'sd0, 16'sd0},
			1'b1, '{CLS_RUN, 24'd1, 1'b1}},
		'{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd0},
			1'b0, '0},
		'{'{16'sd0, 16'sd0, 16'sd0, 16'sh8000, 16'sh8000, 16'sh8000},
			1'b0, '0},
		'{'{16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
			1'b0, '0},
		// exactly gravity + step limit: not a step
		'{'{16'sd0, 16'sd0, 16'sd2893, 16'sd0, 16'sd0, 16'sd0},
			1'b0, '0},
		// one above: a step
		'{'{16'sd0, 16'sd0, 16'sd2894, 16'sd0, 16'sd0, 16'sd0},
			1'b0, '0},
		'{'{-16'sd2894, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
			1'b0, '0},
		'{'{16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF},
			1'b0, '0},
		'{'{16'sh7FFF, 16'sh8000, 16'sd1, -16'sd1, 16'sh5555, 16'shAAAA},
			1'b0, '0},
		'{'{16'sd0, 16'sh8000, 16'sd0, 16'sh8000, 16'sd0, 16'sh7FFF},
			1'b0, '0},
		'{'{16'sd0, 16'sd0, 16'sd2509, 16'sd0, 16'sd0, 16'sd0},
			1'b0, '0},
		'{'{16'sd0, 16'sd0, -16'sd2509, 16'sd3, -16'sd2, 16'sd1},
			1'b0, '0},
		// floors just below gravity, then exactly at it
		'{'{16'sd1774, 16'sd1774, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
			1'b0, '0},
		'{'{16'sd0, 16'sd2509, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
			1'b0, '0}
	};

	function automatic int unsigned floor_root(input longint unsigned v);
		int unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 15; b >= 0; b--) begin
			t = r | (32'd1 << b);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	function automatic int unsigned norm3(input logic signed [FIELD_W-1:0] a,
		input logic signed [FIELD_W-1:0] b, input logic signed [FIELD_W-1:0] c);
		longint x, y, z;
		x = a;
		y = b;
		z = c;
		return floor_root(longint'(x * x + y * y + z * z));
	endfunction

	function automatic void reset_predictor();
		grav_lvl      = GRAV_RST;
		still_acc_lim = STILL_ACCEL_RST;
		still_rot_lim = STILL_GYRO_RST;
		walk_lim      = WALK_RST;
		run_lim       = RUN_RST;
		step_lim      = STEP_LIM_RST;
		foreach (acc_ring[i]) begin
			acc_ring[i] = '0;
			rot_ring[i] = '0;
		end
		ring_slot      = 0;
		acc_window_sum = 0;
		rot_window_sum = 0;
		step_tally     = '0;
	endfunction

	// Register file copy: only the register's own width survives.
	function automatic void mirror_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_GRAVITY:     grav_lvl      = data[GRAV_W-1:0];
			REG_STILL_ACCEL: still_acc_lim = data[LIM_W-1:0];
			REG_STILL_GYRO:  still_rot_lim = data[LIM_W-1:0];
			REG_WALK:        walk_lim      = data[LIM_W-1:0];
			REG_RUN:         run_lim       = data[LIM_W-1:0];
			REG_STEP:        step_lim      = data[LIM_W-1:0];
			default: ;
		endcase
	endfunction

	// Window update, classification and step test for one accepted sample.
	function automatic step_report_t track_motion(input sample_t s);
		step_report_t r;
		int unsigned amag, rmag, g;
		amag = norm3(s.accel_x, s.accel_y, s.accel_z);
		rmag = norm3(s.rate_x, s.rate_y, s.rate_z);
		g    = grav_lvl;

		// new sample goes in first, then the whole window is judged
		acc_window_sum = acc_window_sum - acc_ring[ring_slot] + amag;
		rot_window_sum = rot_window_sum - rot_ring[ring_slot] + rmag;
		acc_ring[ring_slot] = MAG_W'(amag);
		rot_ring[ring_slot] = MAG_W'(rmag);
		ring_slot = (ring_slot + 1) % WIN;

		// average tests scaled by the window length instead of divided
		if (acc_window_sum < WIN * (g + still_acc_lim) &&
			rot_window_sum < WIN * still_rot_lim)
			r.cls = CLS_STAND;
		else if (acc_window_sum < WIN * (g + walk_lim))
			r.cls = CLS_WALK;
		else if (acc_window_sum < WIN * (g + run_lim))
			r.cls = CLS_RUN;
		else
			r.cls = CLS_JUMP;

		// strict step test; the total sticks at all ones
		r.seen = (amag > g + step_lim);
		if (r.seen && step_tally != STEP_MAX)
			step_tally++;
		r.total = step_tally;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	function automatic logic signed [FIELD_W-1:0] around(input int centre, input int amp);
		int v;
		v = int'($urandom_range(0, 2 * amp)) - amp + centre;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return FIELD_W'(v);
	endfunction

	// Sample shaped like the given movement, gravity on z (sometimes upside down).
	function automatic sample_t shake(input gait_t g);
		sample_t s;
		int dev, spin, up;
		case (g)
			GAIT_STILL: begin dev = 40;   spin = 40;   end
			GAIT_WALK:  begin dev = 900;  spin = 300;  end
			GAIT_RUN:   begin dev = 2200; spin = 1200; end
			GAIT_JUMP:  begin dev = 8000; spin = 4000; end
			default:    begin dev = 60;   spin = 6000; end
		endcase
		up = ($urandom_range(0, 7) == 0) ? -int'(grav_lvl) : int'(grav_lvl);
		if (g == GAIT_NOISE) begin
			s = {$urandom, $urandom, $urandom};
		end else begin
			s.accel_x = around(0, dev / 2);
			s.accel_y = around(0, dev / 2);
			s.accel_z = around(up, dev);
			s.rate_x  = around(0, spin);
			s.rate_y  = around(0, spin);
			s.rate_z  = around(0, spin);
		end
		return s;
	endfunction

	// One sample transfer. valid is left high; the next call either reuses it
	// or drops it before its idle gap, so no step sees two writes to it.
	task automatic feed(input sample_t s, input bit eager, input bit pinned,
		input step_report_t fixed);
		step_report_t want;
		if (!eager && !quiet_tail && $urandom_range(0, 2) == 0) begin
			smp_bus.valid <= 1'b0;
			do
				repeat ($urandom_range(1, 11)) @(posedge clk);
			while ($urandom_range(0, 3) == 0);
		end
		smp_bus.valid   <= 1'b1;
		smp_bus.accel_x <= s.accel_x;
		smp_bus.accel_y <= s.accel_y;
		smp_bus.accel_z <= s.accel_z;
		smp_bus.rate_x  <= s.rate_x;
		smp_bus.rate_y  <= s.rate_y;
		smp_bus.rate_z  <= s.rate_z;
		do
			@(posedge clk);
		while (!smp_bus.ready);
		want = track_motion(s);
		if (pinned)
			want = fixed;
		expected_reports.push_back(want);
		samples_in++;
	endtask

	// Runs of one movement kind, broken up now and then by short noise bursts.
	task automatic roam(input int count, input bit eager);
		int left, run_len;
		gait_t g;
		left = count;
		while (left > 0) begin
			g = gait_t'($urandom_range(0, GAIT_NOISE));
			run_len = (g == GAIT_NOISE) ? $urandom_range(1, 4) : $urandom_range(8, 40);
			while (run_len > 0 && left > 0) begin
				feed(shake(g), eager, 1'b0, '0);
				run_len--;
				left--;
			end
		end
	endtask

	// Drain: valid down, all results back, then a few spare cycles.
	task automatic settle(input int unsigned tail);
		smp_bus.valid <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= data;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		mirror_reg(idx, data);
	endtask

	// Back-to-back writes of all six registers, optionally with stray indexes.
	task automatic apply_settings(input logic [CFG_DATA_W-1:0] g,
		input logic [CFG_DATA_W-1:0] sa, input logic [CFG_DATA_W-1:0] sg,
		input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] r,
		input logic [CFG_DATA_W-1:0] st, input bit stray);
		if (stray)
			write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
		write_reg(REG_GRAVITY, g);
		write_reg(REG_STILL_ACCEL, sa);
		write_reg(REG_STILL_GYRO, sg);
		write_reg(REG_WALK, w);
		write_reg(REG_RUN, r);
		write_reg(REG_STEP, st);
		if (stray)
			write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	// ---------------------------------------------------------------
	// Result side: random ready bursts, one long hold, checking
	// ---------------------------------------------------------------
	task automatic check_report();
		step_report_t want;
		if (expected_reports.size() == 0) begin
			$error("result transfer with no sample outstanding");
			faults++;
		end else begin
			want = expected_reports.pop_front();
			if (res_bus.motion_class !== want.cls) begin
				$error("motion_class: expected %0d, got %0d", want.cls, res_bus.motion_class);
				faults++;
			end
			if (res_bus.step_total !== want.total) begin
				$error("step_total: expected %0d, got %0d", want.total, res_bus.step_total);
				faults++;
			end
			if (res_bus.step_seen !== want.seen) begin
				$error("step_seen: expected %0d, got %0d", want.seen, res_bus.step_seen);
				faults++;
			end
			class_hits[want.cls]++;
			if (want.seen)
				steps_flagged++;
		end
		reports_out++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_bus.valid && res_bus.ready)
				check_report();
			if (hold_left != 0) begin
				hold_left--;
				res_bus.ready <= 1'b0;
			end else if (hold_go && !hold_done) begin
				// long stall: core fills its output register and then its input stalls
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
				res_bus.ready <= 1'b0;
			end else if (quiet_tail) begin
				res_bus.ready <= 1'b1;
			end else if (burst_left != 0) begin
				burst_left--;
			end else begin
				res_bus.ready <= ($urandom_range(0, 2) != 0);
				burst_left = $urandom_range(1, 11) - 1;
			end
		end
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n          = 1'b0;
		smp_bus.valid   = 1'b0;
		smp_bus.accel_x = '0;
		smp_bus.accel_y = '0;
		smp_bus.accel_z = '0;
		smp_bus.rate_x  = '0;
		smp_bus.rate_y  = '0;
		smp_bus.rate_z  = '0;
		res_bus.ready   = 1'b0;
		cfg_bus.valid   = 1'b0;
		cfg_bus.index   = '0;
		cfg_bus.data    = '0;
		quiet_tail      = 1'b0;
		hold_go         = 1'b0;
		hold_done       = 1'b0;
		hold_left       = 0;
		burst_left      = 0;
		faults          = 0;
		samples_in      = 0;
		reports_out     = 0;
		steps_flagged   = 0;
		settings_used   = 1;
		class_hits      = '{default: 0};
		reset_predictor();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values, window filling up from zero: directed rows first.
		// Counter saturation would need 2^24 steps and is out of reach in this run.
		foreach (probes[i])
			feed(probes[i].s, 1'b0, probes[i].pinned, probes[i].want);
		roam(400, 1'b0);
		settle(8);

		// All registers at zero: every nonzero sample is a step, never standing.
		apply_settings('0, '0, '0, '0, '0, '0, 1'b1);
		roam(200, 1'b0);
		settle(8);

		// All ones: gravity keeps only its low 12 bits.
		apply_settings('1, '1, '1, '1, '1, '1, 1'b0);
		roam(200, 1'b0);

		// Back-pressure: the receiver stalls while samples keep coming.
		hold_go <= 1'b1;
		roam(30, 1'b1);
		settle(8);

		// Random settings; the first uses full 14-bit data everywhere.
		for (int k = 0; k < 4; k++) begin
			if (k == 0)
				apply_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
					CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
					CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), 1'b0);
			else
				apply_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(0, 600)),
					CFG_DATA_W'($urandom_range(0, 600)),
					CFG_DATA_W'($urandom_range(0, 3000)),
					CFG_DATA_W'($urandom_range(0, 6000)),
					CFG_DATA_W'($urandom_range(0, 4000)), k[0]);
			roam(200, 1'b0);
			settle(8);
		end

		// Back to reset values, no idling on either side.
		apply_settings(CFG_DATA_W'(GRAV_RST), STILL_ACCEL_RST, STILL_GYRO_RST,
			WALK_RST, RUN_RST, STEP_LIM_RST, 1'b0);
		quiet_tail <= 1'b1;
		roam(200, 1'b0);
		settle(60);

		$display("%0d samples, %0d results checked over %0d register settings",
			samples_in, reports_out, settings_used);
		$display("classes stand/walk/run/jump: %0d/%0d/%0d/%0d, %0d steps flagged",
			class_hits[CLS_STAND], class_hits[CLS_WALK], class_hits[CLS_RUN],
			class_hits[CLS_JUMP], steps_flagged);
		if (faults == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#8ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/mcsc_pkg.sv
hw/rtl/mcsc_if.sv
hw/rtl/mcsc_isqrt.sv
hw/rtl/mcsc_dp.sv
hw/rtl/mcsc_ctrl.sv
hw/rtl/motion_classifier_step_counter_core.sv
tb/tb.sv
